/* design/pbrf_pkg.sv */
`default_nettype none

package pbrf_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int VALUE_BITS = 64;
  localparam int FIELD_BITS = 61;
  localparam int SHIFT_BITS = 7;

  // Byte counts of the fixed-size bodies.
  localparam int FIXED64_BYTES = 8;
  localparam int FIXED32_BYTES = 4;

  localparam logic [7:0] GROUP_MASK = 8'h7F;
  localparam logic [7:0] CONT_MASK  = 8'h80;
  localparam logic [7:0] WT_MASK    = 8'h07;

  typedef enum logic [2:0] {
    WT_VARINT  = 3'd0,
    WT_FIXED64 = 3'd1,
    WT_LENGTH  = 3'd2,
    WT_FIXED32 = 3'd5
  } wire_type_t;

  typedef enum logic [1:0] {
    PH_TAG    = 2'd0,
    PH_VALUE  = 2'd1,
    PH_LENGTH = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_COMPLETE  = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_OVERRUN   = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] device_address;
    logic [VALUE_BITS-1:0] request_kind;
    status_t               parse_status;
  } result_t;

  // Parser state as seen from outside the decoder.
  typedef struct packed {
    phase_t phase;
    logic   shift_zero;
    logic   skip_pending;
  } dec_view_t;

endpackage

`default_nettype wire

/* design/pbrf_input_stage.sv */
`default_nettype none

module pbrf_input_stage
  import pbrf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  load,
  input  wire item_t item_in,
  input  wire logic  consume,
  output logic       held,
  output item_t      item_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (consume) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_q <= item_in;
    end
  end

endmodule

`default_nettype wire

/* design/pbrf_decode.sv */
`default_nettype none

module pbrf_decode
  import pbrf_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step,
  input  wire item_t item,
  output result_t    result,
  output dec_view_t  view
);

  localparam logic [VALUE_BITS-1:0] LenMax =
    (LENGTH_BITS >= VALUE_BITS) ? {VALUE_BITS{1'b1}}
                                : ((VALUE_BITS'(1) << LENGTH_BITS) - VALUE_BITS'(1));

  phase_t                 phase, phase_next;
  logic [VALUE_BITS-1:0]  accumulator, accumulator_next;
  logic [SHIFT_BITS-1:0]  bit_shift, bit_shift_next;
  logic [FIELD_BITS-1:0]  current_field, current_field_next;
  logic [LENGTH_BITS-1:0] skip_remaining, skip_remaining_next;
  logic [VALUE_BITS-1:0]  address_value, address_value_next;
  logic [VALUE_BITS-1:0]  kind_value, kind_value_next;

  logic [VALUE_BITS-1:0] acc_tmp;
  logic [SHIFT_BITS-1:0] shift_tmp;
  logic [VALUE_BITS-1:0] len_sat;
  logic [2:0]            wt;
  logic [7:0]            group;

  always_comb begin
    phase_next          = phase;
    accumulator_next    = accumulator;
    bit_shift_next      = bit_shift;
    current_field_next  = current_field;
    skip_remaining_next = skip_remaining;
    address_value_next  = address_value;
    kind_value_next     = kind_value;
    group     = item.data_byte & GROUP_MASK;
    acc_tmp   = accumulator;
    shift_tmp = bit_shift;
    wt        = acc_tmp[2:0] & WT_MASK[2:0];
    len_sat   = (acc_tmp > LenMax) ? LenMax : acc_tmp;

    if (step && item.byte_valid) begin
      if (phase == PH_SKIP) begin
        if (skip_remaining != '0) begin
          skip_remaining_next = skip_remaining - LENGTH_BITS'(1);
        end
        if (skip_remaining_next == '0) begin
          phase_next = PH_TAG;
        end
      end else begin
        // Groups at bit 64 and beyond are dropped; the shift stops there.
        if (!bit_shift[SHIFT_BITS-1]) begin
          acc_tmp   = accumulator | (VALUE_BITS'(group[6:0]) << bit_shift[5:0]);
          shift_tmp = bit_shift + SHIFT_BITS'(7);
        end
        wt      = acc_tmp[2:0] & WT_MASK[2:0];
        len_sat = (acc_tmp > LenMax) ? LenMax : acc_tmp;
        if ((item.data_byte & CONT_MASK) == 8'h00) begin
          accumulator_next = '0;
          bit_shift_next   = '0;
          unique case (phase)
            PH_TAG: begin
              current_field_next = acc_tmp[VALUE_BITS-1:3];
              unique case (wt)
                WT_VARINT:  phase_next = PH_VALUE;
                WT_LENGTH:  phase_next = PH_LENGTH;
                WT_FIXED64: begin
                  phase_next          = PH_SKIP;
                  skip_remaining_next = LENGTH_BITS'(FIXED64_BYTES);
                end
                WT_FIXED32: begin
                  phase_next          = PH_SKIP;
                  skip_remaining_next = LENGTH_BITS'(FIXED32_BYTES);
                end
                default: phase_next = PH_TAG;
              endcase
            end
            PH_VALUE: begin
              if (current_field == FIELD_BITS'(1)) begin
                address_value_next = acc_tmp;
              end else if (current_field == FIELD_BITS'(2)) begin
                kind_value_next = acc_tmp;
              end
              phase_next = PH_TAG;
            end
            default: begin
              if (len_sat == '0) begin
                phase_next = PH_TAG;
              end else begin
                skip_remaining_next = len_sat[LENGTH_BITS-1:0];
                phase_next          = PH_SKIP;
              end
            end
          endcase
        end else begin
          accumulator_next = acc_tmp;
          bit_shift_next   = shift_tmp;
        end
      end
    end

    result.device_address = address_value_next;
    result.request_kind   = kind_value_next;
    if (phase_next == PH_SKIP) begin
      result.parse_status = ST_OVERRUN;
    end else if (phase_next == PH_TAG && bit_shift_next == '0) begin
      result.parse_status = ST_COMPLETE;
    end else begin
      result.parse_status = ST_TRUNCATED;
    end

    // The end of a payload returns the parser to its start state.
    if (step && item.last_byte) begin
      phase_next          = PH_TAG;
      accumulator_next    = '0;
      bit_shift_next      = '0;
      current_field_next  = '0;
      skip_remaining_next = '0;
      address_value_next  = '0;
      kind_value_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TAG;
      accumulator    <= '0;
      bit_shift      <= '0;
      current_field  <= '0;
      skip_remaining <= '0;
      address_value  <= '0;
      kind_value     <= '0;
    end else begin
      phase          <= phase_next;
      accumulator    <= accumulator_next;
      bit_shift      <= bit_shift_next;
      current_field  <= current_field_next;
      skip_remaining <= skip_remaining_next;
      address_value  <= address_value_next;
      kind_value     <= kind_value_next;
    end
  end

  assign view.phase        = phase;
  assign view.shift_zero   = (bit_shift == '0);
  assign view.skip_pending = (skip_remaining != '0);

endmodule

`default_nettype wire

/* design/pbrf_output_stage.sv */
`default_nettype none

module pbrf_output_stage
  import pbrf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t result_in,
  input  wire logic    out_stall,
  output logic         out_valid,
  output result_t      result_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

`default_nettype wire

/* design/protobuf_request_field_parser.sv */
// Channel  Handshake             Payload
// in       in_valid / in_stall   data_byte[7:0], byte_valid, last_byte
// out      out_valid / out_stall device_address[63:0], request_kind[63:0],
//                                parse_status[1:0]
//
// One request is accepted per cycle while in_stall is low. A byte is registered,
// then decoded into the parser state when it leaves the input register; a
// last_byte request also loads the result register at that edge.
// Reset is synchronous and clears the parser to the expecting-tag state.
// in_stall rises only while a held last_byte request waits on a stalled,
// full result register.
`default_nettype none

module protobuf_request_field_parser
  import pbrf_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      device_address,
  output logic [63:0]      request_kind,
  output logic [1:0]       parse_status
);

  item_t     item_in, item_q;
  logic      held, consume, accept;
  result_t   dec_result, result_q;
  dec_view_t view;

  assign item_in.data_byte  = data_byte;
  assign item_in.byte_valid = byte_valid;
  assign item_in.last_byte  = last_byte;

  // Only a request that ends a payload needs room in the result register.
  assign consume  = held && (!item_q.last_byte || !out_valid || !out_stall);
  assign in_stall = held && !consume;
  assign accept   = in_valid && !in_stall;

  pbrf_input_stage u_input (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .item_in (item_in),
    .consume (consume),
    .held    (held),
    .item_q  (item_q)
  );

  pbrf_decode #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decode (
    .clk    (clk),
    .rst    (rst),
    .step   (consume),
    .item   (item_q),
    .result (dec_result),
    .view   (view)
  );

  pbrf_output_stage u_output (
    .clk       (clk),
    .rst       (rst),
    .load      (consume && item_q.last_byte),
    .result_in (dec_result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .result_q  (result_q)
  );

  assign device_address = result_q.device_address;
  assign request_kind   = result_q.request_kind;
  assign parse_status   = result_q.parse_status;

`ifndef ASSERT_OFF
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(consume && item_q.last_byte))
    else $error("result appeared without a payload end");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    consume && item_q.last_byte |=> view.phase == PH_TAG && view.shift_zero)
    else $error("parser not back at tag start after payload end");

  a_skip_has_bytes: assert property (@(posedge clk) disable iff (rst)
    view.phase == PH_SKIP |-> view.skip_pending)
    else $error("skip phase with no bytes left to skip");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> held && item_q.last_byte && out_valid && out_stall)
    else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

/* tb/sv/request_parse_checker.sv */
`timescale 1ns / 1ps

module request_parse_checker
  import pbrf_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT,
  parameter logic [FIELD_BITS-1:0] ADDRESS_FIELD = 1,
  parameter logic [FIELD_BITS-1:0] KIND_FIELD = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] device_address,
  input  logic [63:0] request_kind,
  input  logic [1:0]  parse_status,
  output int          fail_count,
  output int          pending_count
);

  localparam logic [63:0] LENGTH_CAP =
    (LENGTH_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);

  phase_t                parse_phase;
  logic [63:0]           gathered;
  logic [SHIFT_BITS-1:0] group_shift;
  logic [FIELD_BITS-1:0] field_number;
  logic [63:0]           body_left;
  logic [63:0]           address_seen;
  logic [63:0]           kind_seen;

  result_t predicted_parses[$];

  task automatic restart_parser();
    parse_phase  = PH_TAG;
    gathered     = '0;
    group_shift  = '0;
    field_number = '0;
    body_left    = '0;
    address_seen = '0;
    kind_seen    = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic finish_varint(input logic [63:0] v);
    logic [63:0] len;
    case (parse_phase)
      PH_TAG: begin
        field_number = v[63:3];
        case (v[2:0])
          WT_VARINT:  parse_phase = PH_VALUE;
          WT_LENGTH:  parse_phase = PH_LENGTH;
          WT_FIXED64: begin
            parse_phase = PH_SKIP;
            body_left   = 64'(FIXED64_BYTES);
          end
          WT_FIXED32: begin
            parse_phase = PH_SKIP;
            body_left   = 64'(FIXED32_BYTES);
          end
          default:    parse_phase = PH_TAG;
        endcase
      end
      PH_VALUE: begin
        if (field_number == ADDRESS_FIELD) address_seen = v;
        else if (field_number == KIND_FIELD) kind_seen = v;
        parse_phase = PH_TAG;
      end
      default: begin
        len = (v > LENGTH_CAP) ? LENGTH_CAP : v;
        if (len == 64'd0) begin
          parse_phase = PH_TAG;
        end else begin
          body_left   = len;
          parse_phase = PH_SKIP;
        end
      end
    endcase
  endtask

  task automatic decode_request(input logic [7:0] b, input logic carries, input logic ends);
    result_t summary;
    if (carries) begin
      if (parse_phase == PH_SKIP) begin
        if (body_left != 64'd0) body_left = body_left - 64'd1;
        if (body_left == 64'd0) parse_phase = PH_TAG;
      end else begin
        // Groups at bit 64 and above are dropped and the shift stops there.
        if (group_shift < 7'd64) begin
          gathered    = gathered | (64'(b & GROUP_MASK) << group_shift);
          group_shift = group_shift + 7'd7;
        end
        if ((b & CONT_MASK) == 8'h00) begin
          summary.device_address = gathered;
          gathered    = '0;
          group_shift = '0;
          finish_varint(summary.device_address);
        end
      end
    end
    if (ends) begin
      summary.device_address = address_seen;
      summary.request_kind   = kind_seen;
      if (parse_phase == PH_SKIP) summary.parse_status = ST_OVERRUN;
      else if (parse_phase == PH_TAG && group_shift == '0) summary.parse_status = ST_COMPLETE;
      else summary.parse_status = ST_TRUNCATED;
      predicted_parses.push_back(summary);
      restart_parser();
    end
  endtask

  always @(posedge clk) begin : watch_channels
    result_t want;
    if (rst) begin
      restart_parser();
      predicted_parses.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_parses.size() == 0) begin
          report_mismatch($sformatf("result with none expected: address %h kind %h status %0d",
                                    device_address, request_kind, parse_status));
        end else begin
          want = predicted_parses.pop_front();
          if (device_address !== want.device_address)
            report_mismatch($sformatf("device_address %h, expected %h",
                                      device_address, want.device_address));
          if (request_kind !== want.request_kind)
            report_mismatch($sformatf("request_kind %h, expected %h",
                                      request_kind, want.request_kind));
          if (parse_status !== want.parse_status)
            report_mismatch($sformatf("parse_status %0d, expected %0d",
                                      parse_status, want.parse_status));
        end
      end
      if (in_valid && !in_stall) decode_request(data_byte, byte_valid, last_byte);
    end
    pending_count = predicted_parses.size();
  end

endmodule

/* tb/sv/protobuf_request_field_parser_tb.sv */
`timescale 1ns / 1ps

module protobuf_request_field_parser_tb;
  import pbrf_pkg::*;

  localparam logic [FIELD_BITS-1:0] ADDRESS_FIELD = 1;
  localparam logic [FIELD_BITS-1:0] KIND_FIELD = 2;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_valid = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] device_address;
  logic [63:0] request_kind;
  logic [1:0]  parse_status;

  int fail_count;
  int pending_count;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int idle_step_pct = 0;
  int items_sent = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  logic [7:0] payload[$];

  always #10 clk = ~clk;

  protobuf_request_field_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .byte_valid(byte_valid), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .device_address(device_address), .request_kind(request_kind),
    .parse_status(parse_status)
  );

  request_parse_checker #(
    .ADDRESS_FIELD(ADDRESS_FIELD),
    .KIND_FIELD(KIND_FIELD)
  ) parse_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .byte_valid(byte_valid), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .device_address(device_address), .request_kind(request_kind),
    .parse_status(parse_status),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Receiver: random stalls, or a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("protobuf_request_field_parser test failed");
      $finish;
    end
  end

  task automatic send_req(input logic [7:0] value, input logic carries, input logic ends);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid   <= 1'b1;
    data_byte  <= value;
    byte_valid <= carries;
    last_byte  <= ends;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // Sends the payload queue; the end is either flagged on the final byte or
  // given by an empty end marker.
  task automatic send_payload(input bit end_marker);
    for (int i = 0; i < payload.size(); i++) begin
      if ($urandom_range(99) < idle_step_pct) send_req(8'($urandom), 1'b0, 1'b0);
      send_req(payload[i], 1'b1, !end_marker && i == payload.size() - 1);
      items_sent++;
    end
    if (end_marker || payload.size() == 0) begin
      send_req(8'($urandom), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int k;
    v = {$urandom(), $urandom()};
    k = $urandom_range(64);
    if ($urandom_range(9) == 0) return {64{1'b1}};
    if (k < 64) v = v & ((64'd1 << k) - 64'd1);
    return v;
  endfunction

  function automatic int pad_groups();
    return ($urandom_range(9) == 0) ? $urandom_range(1, 12) : 0;
  endfunction

  // Appends a varint with optional redundant groups. Groups past the tenth
  // land above bit 63, so they carry random bits the parser must drop.
  task automatic put_varint(input logic [63:0] v, input int pad);
    int groups;
    logic [6:0] grp;
    groups = 0;
    forever begin
      groups++;
      if ((v >> 7) == 64'd0 && pad == 0) begin
        payload.push_back({1'b0, v[6:0]});
        break;
      end
      payload.push_back({1'b1, v[6:0]});
      v = v >> 7;
      if (v == 64'd0) break;
    end
    for (int p = 0; p < pad; p++) begin
      groups++;
      grp = (groups > 10) ? 7'($urandom) : 7'd0;
      payload.push_back({p != pad - 1, grp});
    end
  endtask

  task automatic put_field(output bit stop_now);
    logic [FIELD_BITS-1:0] fnum;
    logic [63:0] draw;
    logic [63:0] len;
    logic [2:0] wt;
    int pick;
    stop_now = 1'b0;
    pick = $urandom_range(99);
    draw = {$urandom(), $urandom()};
    if (pick < 40) fnum = ADDRESS_FIELD;
    else if (pick < 70) fnum = KIND_FIELD;
    else if (pick < 90) fnum = 61'($urandom_range(3, 20));
    else fnum = draw[FIELD_BITS-1:0];
    pick = $urandom_range(99);
    if (pick < 55) wt = WT_VARINT;
    else if (pick < 75) wt = WT_LENGTH;
    else if (pick < 83) wt = WT_FIXED64;
    else if (pick < 91) wt = WT_FIXED32;
    else if ($urandom_range(1) == 0) wt = 3'($urandom_range(3, 4));
    else wt = 3'($urandom_range(6, 7));
    put_varint({fnum, wt}, pad_groups());
    case (wt)
      WT_VARINT: put_varint(rand_value(), pad_groups());
      WT_LENGTH: begin
        // A body too long to send ends the payload with bytes still owed.
        if ($urandom_range(14) == 0) begin
          stop_now = 1'b1;
          len = rand_value() | (64'd1 << $urandom_range(8, 63));
          put_varint(len, pad_groups());
          repeat ($urandom_range(0, 3)) payload.push_back(8'($urandom));
        end else begin
          len = 64'($urandom_range(0, 6));
          put_varint(len, pad_groups());
          repeat (len) payload.push_back(8'($urandom));
        end
      end
      WT_FIXED64: repeat (FIXED64_BYTES) payload.push_back(8'($urandom));
      WT_FIXED32: repeat (FIXED32_BYTES) payload.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  task automatic make_random_payload();
    int pick;
    int nf;
    int cut;
    bit stop_now;
    payload.delete();
    pick = $urandom_range(99);
    stop_now = 1'b0;
    if (pick < 10) begin
      repeat ($urandom_range(1, 12)) payload.push_back(8'($urandom));
    end else begin
      nf = $urandom_range(0, 5);
      for (int i = 0; i < nf && !stop_now; i++) put_field(stop_now);
      // Some well-formed payloads are cut short at a random byte.
      if (pick < 30 && payload.size() > 0) begin
        cut = $urandom_range(payload.size() - 1);
        while (payload.size() > cut) payload.delete(payload.size() - 1);
      end
    end
  endtask

  task automatic run_random(input int n_items, input int src_pct, input int sink_pct);
    int stop_at;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      make_random_payload();
      send_payload($urandom_range(3) == 0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty payload, then an idle step that must change nothing.
    payload.delete();
    send_payload(1'b1);
    send_req(8'hA5, 1'b0, 1'b0);
    // Both kept fields, then a fixed 4-byte body ending exactly at the end.
    payload = '{8'h08, 8'h01, 8'h10, 8'hFF, 8'h7F, 8'h0D, 8'h5A, 8'hC3, 8'h00, 8'hFF};
    send_payload(1'b0);
    // Length above the cap saturates and leaves the body unfinished.
    payload = '{8'h1A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    send_payload(1'b0);
    // Zero-length body, a type with no body, then an unfinished value.
    payload = '{8'h12, 8'h00, 8'h1B, 8'h08, 8'h80};
    send_payload(1'b0);
    // Payload ending right after a fixed 8-byte tag.
    payload = '{8'h09};
    send_payload(1'b0);

    idle_step_pct = 8;
    run_random(230, 0, 0);
    run_random(170, 79, 0);
    run_random(170, 0, 79);
    run_random(220, 25, 25);

    // Hold the receiver off while short requests keep coming, so the block
    // fills and stalls its input.
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_requests++;
    repeat (40) begin
      payload.delete();
      if ($urandom_range(1) == 0) payload.push_back(8'($urandom));
      send_payload(1'b0);
    end
    run_random(40, 25, 25);

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("protobuf_request_field_parser test passed");
    end else begin
      $display("protobuf_request_field_parser test failed");
    end
    $finish;
  end

endmodule
